// ===== src/vca_pkg.sv =====
// Package for the voice channel allocator: field widths, codes, the queue
// entry type and the queue status type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package vca_pkg;

   // Built channel count default and result limit per request.
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int MAX_RESULTS      = 8;
   localparam int QUEUE_DEPTH      = 2;

   // Field widths.
   localparam int OPCODE_W   = 2;
   localparam int ORIGIN_W   = 16;
   localparam int SOUND_W    = 10;
   localparam int PRIO_W     = 8;
   localparam int CHAN_W     = 3;
   localparam int KIND_W     = 2;
   localparam int ACTIVE_W   = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 4;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_START    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SILENCE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_STOP_ALL = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_ENDED    = 2'd3;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_STOPPED  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REFUSED  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOTHING  = 2'd3;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_CHANNELS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEGACY_STOP     = 4'd1;
   localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET        = 4'd8;

   // Class of a request as decided by the front end.
   typedef enum logic [2:0] {
      CLS_START,
      CLS_SILENCE,
      CLS_STOP_ALL,
      CLS_ENDED,
      CLS_NOP
   } cls_type;

   // One queued request.
   typedef struct packed {
      cls_type             cls;
      logic [ORIGIN_W-1:0] origin_id;
      logic [SOUND_W-1:0]  sound_id;
      logic [PRIO_W-1:0]   priority_req;
      logic                pickup_flag;
      logic [CHAN_W-1:0]   ended_channel;
      logic                org_nz;
   } item_type;

   // Queue fill status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== src/vca_if.sv =====
// Channel interfaces of the voice channel allocator: request, result and
// configuration write channels, each with valid and ready.
// Depends on vca_pkg for the field widths.
`default_nettype none

interface vca_req_if;
   import vca_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ORIGIN_W-1:0] origin_id;
   logic [SOUND_W-1:0]  sound_id;
   logic [PRIO_W-1:0]   priority_req;
   logic                pickup_flag;
   logic [CHAN_W-1:0]   ended_channel;

   modport source (output valid, opcode, origin_id, sound_id, priority_req, pickup_flag,
                   ended_channel, input ready);
   modport sink   (input valid, opcode, origin_id, sound_id, priority_req, pickup_flag,
                   ended_channel, output ready);
endinterface

interface vca_rsp_if;
   import vca_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CHAN_W-1:0]  channel;
   logic [SOUND_W-1:0] sound_id_res;
   logic               last;

   modport source (output valid, kind, channel, sound_id_res, last, input ready);
   modport sink   (input valid, kind, channel, sound_id_res, last, output ready);
endinterface

interface vca_csr_if;
   import vca_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/vca_front.sv =====
// Front end of the voice channel allocator: accepts requests and classifies
// them into queue entries.
// Depends on vca_pkg and vca_req_if.
`default_nettype none

module vca_front #(
   parameter int MAX_CHANNELS = vca_pkg::MAX_CHANNELS_DEF
) (
   vca_req_if.sink                      req_ch,
   input  logic [$clog2(MAX_CHANNELS+1)-1:0] live_n,
   input  vca_pkg::queue_status_type    q_status,
   output logic                         push,
   output vca_pkg::item_type            push_item
);
   import vca_pkg::*;

   // A request is taken whenever the queue has room.
   assign req_ch.ready = !q_status.full;
   assign push         = req_ch.valid && !q_status.full;

   // Classify the request; a voice-ended request on an inactive channel
   // can do nothing, so it is marked as such here.
   always_comb begin
      push_item.origin_id     = req_ch.origin_id;
      push_item.sound_id      = req_ch.sound_id;
      push_item.priority_req  = req_ch.priority_req;
      push_item.pickup_flag   = req_ch.pickup_flag;
      push_item.ended_channel = req_ch.ended_channel;
      push_item.org_nz        = (req_ch.origin_id != '0);
      unique case (req_ch.opcode)
         OP_START:    push_item.cls = CLS_START;
         OP_SILENCE:  push_item.cls = CLS_SILENCE;
         OP_STOP_ALL: push_item.cls = CLS_STOP_ALL;
         OP_ENDED: begin
            if (32'(req_ch.ended_channel) < 32'(live_n)) begin
               push_item.cls = CLS_ENDED;
            end else begin
               push_item.cls = CLS_NOP;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/vca_queue.sv =====
// Short queue between the front end and the back end of the allocator.
// Depends on vca_pkg for the entry type and depth.
`default_nettype none

module vca_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  vca_pkg::item_type         push_item,
   input  logic                      pop,
   output vca_pkg::item_type         head,
   output vca_pkg::queue_status_type q_status
);
   import vca_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/vca_back.sv =====
// Back end of the voice channel allocator: the channel table, the step
// sequencer that carries out queued requests, and the result register.
// Depends on vca_pkg and vca_rsp_if.
`default_nettype none

module vca_back #(
   parameter int MAX_CHANNELS = vca_pkg::MAX_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(MAX_CHANNELS+1)-1:0] live_n,
   input  logic                              legacy_stop,
   input  vca_pkg::item_type                 head,
   input  vca_pkg::queue_status_type         q_status,
   output logic                              pop,
   vca_rsp_if.source                         rsp_ch
);
   import vca_pkg::*;

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int RC_W  = $clog2(MAX_RESULTS);

   localparam logic [1:0] ST_FIRST  = 2'd0;
   localparam logic [1:0] ST_PICK   = 2'd1;
   localparam logic [1:0] ST_ASSIGN = 2'd2;

   // Lowest set bit of a channel mask, as a one-hot mask.
   function automatic logic [MAX_CHANNELS-1:0] lowest(input logic [MAX_CHANNELS-1:0] v);
      return v & (~v + MAX_CHANNELS'(1));
   endfunction

   // Channel number of a one-hot mask.
   function automatic logic [IDX_W-1:0] encode(input logic [MAX_CHANNELS-1:0] oh);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (oh[c]) begin
            idx = idx | IDX_W'(c);
         end
      end
      return idx;
   endfunction

   // Channel table.
   logic [MAX_CHANNELS-1:0] busy_ff, busy_in;
   logic [ORIGIN_W-1:0]     origin_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] pickup_ff;
   logic [PRIO_W-1:0]       prio_ff [MAX_CHANNELS];
   logic [SOUND_W-1:0]      sound_ff [MAX_CHANNELS];

   // Sequencer state.
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] tgt_ff, tgt_in;
   logic [RC_W-1:0]  cnt_ff, cnt_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff;
   logic [CHAN_W-1:0]  rsp_chan_ff;
   logic [SOUND_W-1:0] rsp_sound_ff;
   logic               rsp_last_ff;

   // Per-channel match vectors.
   logic [MAX_CHANNELS-1:0] act, live, org_eq, pick_eq, prio_ge, end_eq;
   logic [MAX_CHANNELS-1:0] m_stop1, m_silence, free_m, below_f, m_reuse, m_steal;
   logic [MAX_CHANNELS-1:0] sel;

   // Step outputs.
   logic               out_free;
   logic               emit;
   logic [KIND_W-1:0]  e_kind;
   logic [IDX_W-1:0]   e_idx;
   logic               e_last;
   logic [CHAN_W-1:0]  e_chan;
   logic [SOUND_W-1:0] e_sound;
   logic               wr_en;
   logic               cap_hit;

   // Compare every channel against the request at the queue head.
   always_comb begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         act[c]     = (32'(c) < 32'(live_n));
         org_eq[c]  = (origin_ff[c] == head.origin_id);
         pick_eq[c] = (pickup_ff[c] == head.pickup_flag);
         prio_ge[c] = (prio_ff[c] >= head.priority_req);
         end_eq[c]  = (32'(head.ended_channel) == 32'(c));
      end
   end

   assign live      = busy_ff & act;
   assign m_stop1   = live & org_eq & (legacy_stop ? {MAX_CHANNELS{1'b1}} : pick_eq);
   assign m_silence = live & org_eq;
   assign free_m    = act & ~busy_ff;
   // Channels ahead of the first free one; all channels when none is free.
   assign below_f   = lowest(free_m) - MAX_CHANNELS'(1);
   assign m_reuse   = live & org_eq & pick_eq & below_f & {MAX_CHANNELS{head.org_nz}};
   assign m_steal   = act & prio_ge;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign cap_hit   = (cnt_ff == RC_W'(MAX_RESULTS - 1));

   // One sequencer step per cycle unless the output stalls or the queue is empty, each giving at most one result.
   always_comb begin
      state_in = state_ff;
      tgt_in   = tgt_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      e_kind   = KIND_NOTHING;
      e_idx    = '0;
      e_last   = 1'b1;
      wr_en    = 1'b0;
      sel      = '0;
      if (out_free && !q_status.empty) begin
         unique case (state_ff)
            ST_FIRST: begin
               unique case (head.cls)
                  CLS_START: begin
                     // Stop an older sound of the same origin.
                     if (|m_stop1) begin
                        sel              = lowest(m_stop1);
                        emit             = 1'b1;
                        e_kind           = KIND_STOPPED;
                        e_idx            = encode(sel);
                        e_last           = 1'b0;
                        busy_in          = busy_ff & ~sel;
                     end
                     state_in = ST_PICK;
                  end
                  CLS_SILENCE: begin
                     emit = 1'b1;
                     pop  = 1'b1;
                     if (|m_silence) begin
                        sel     = lowest(m_silence);
                        e_kind  = KIND_STOPPED;
                        e_idx   = encode(sel);
                        busy_in = busy_ff & ~sel;
                     end
                  end
                  CLS_ENDED: begin
                     emit = 1'b1;
                     pop  = 1'b1;
                     if (|(live & end_eq)) begin
                        sel     = live & end_eq;
                        e_kind  = KIND_STOPPED;
                        e_idx   = encode(sel);
                        busy_in = busy_ff & ~sel;
                     end
                  end
                  CLS_STOP_ALL: begin
                     // One busy channel per cycle while not stalled; past the result
                     // limit the rest are freed silently with the last reported one.
                     emit = 1'b1;
                     if (|live) begin
                        sel    = lowest(live);
                        e_kind = KIND_STOPPED;
                        e_idx  = encode(sel);
                        e_last = cap_hit || ((live & ~sel) == '0);
                        busy_in = cap_hit ? (busy_ff & ~live) : (busy_ff & ~sel);
                        if (e_last) begin
                           pop    = 1'b1;
                           cnt_in = '0;
                        end else begin
                           cnt_in = cnt_ff + 1'b1;
                        end
                     end else begin
                        pop    = 1'b1;
                        cnt_in = '0;
                     end
                  end
                  CLS_NOP: begin
                     emit = 1'b1;
                     pop  = 1'b1;
                  end
                  default: begin
                     emit = 1'b1;
                     pop  = 1'b1;
                  end
               endcase
            end
            ST_PICK: begin
               emit = 1'b1;
               if (|m_reuse) begin
                  // Reuse a busy channel of the same origin and flag.
                  sel      = lowest(m_reuse);
                  e_kind   = KIND_STOPPED;
                  e_idx    = encode(sel);
                  e_last   = 1'b0;
                  busy_in  = busy_ff & ~sel;
                  tgt_in   = e_idx;
                  state_in = ST_ASSIGN;
               end else if (|free_m) begin
                  sel          = lowest(free_m);
                  e_kind       = KIND_ASSIGNED;
                  e_idx        = encode(sel);
                  wr_en        = 1'b1;
                  busy_in      = busy_ff | sel;
                  pop          = 1'b1;
                  state_in     = ST_FIRST;
               end else if (|m_steal) begin
                  // Every channel is busy: steal the first one of lower
                  // or equal importance.
                  sel      = lowest(m_steal);
                  e_kind   = KIND_STOPPED;
                  e_idx    = encode(sel);
                  e_last   = 1'b0;
                  busy_in  = busy_ff & ~sel;
                  tgt_in   = e_idx;
                  state_in = ST_ASSIGN;
               end else begin
                  e_kind   = KIND_REFUSED;
                  pop      = 1'b1;
                  state_in = ST_FIRST;
               end
            end
            ST_ASSIGN: begin
               emit            = 1'b1;
               e_kind          = KIND_ASSIGNED;
               e_idx           = tgt_ff;
               wr_en           = 1'b1;
               busy_in         = busy_ff;
               busy_in[tgt_ff] = 1'b1;
               pop             = 1'b1;
               state_in        = ST_FIRST;
            end
            default: begin
               state_in = ST_FIRST;
            end
         endcase
      end
   end

   // Result fields from the step's kind.
   always_comb begin
      unique case (e_kind)
         KIND_STOPPED: begin
            e_chan  = CHAN_W'(e_idx);
            e_sound = sound_ff[e_idx];
         end
         KIND_ASSIGNED: begin
            e_chan  = CHAN_W'(e_idx);
            e_sound = head.sound_id;
         end
         KIND_REFUSED: begin
            e_chan  = '0;
            e_sound = head.sound_id;
         end
         default: begin
            e_chan  = '0;
            e_sound = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         state_ff     <= ST_FIRST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers and table entries.
   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      if (emit) begin
         rsp_kind_ff  <= e_kind;
         rsp_chan_ff  <= e_chan;
         rsp_sound_ff <= e_sound;
         rsp_last_ff  <= e_last;
      end
      if (wr_en) begin
         origin_ff[e_idx] <= head.origin_id;
         pickup_ff[e_idx] <= head.pickup_flag;
         prio_ff[e_idx]   <= head.priority_req;
         sound_ff[e_idx]  <= head.sound_id;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.channel      = rsp_chan_ff;
   assign rsp_ch.sound_id_res = rsp_sound_ff;
   assign rsp_ch.last         = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/voice_channel_allocator.sv =====
// Voice channel allocator. Requests (start, silence origin, stop all, voice
// ended) are taken into a two-entry queue while it has room, so the block
// keeps accepting while a result waits on the output register. The back end
// issues at most one result per cycle: silence, voice ended and no-op requests
// take a single step, a start takes a stop step, then a pick step, and an
// assign step when it reuses or steals a busy channel, and stop all takes one
// step per result, at least one and at most eight results. Every request
// ends with a result flagged last. Busy bits clear at reset; no clearing
// pass is run. Configuration writes are always ready.
// Depends on vca_pkg, vca_if, vca_front, vca_queue and vca_back.
`default_nettype none

module voice_channel_allocator #(
   parameter int MAX_CHANNELS = vca_pkg::MAX_CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   vca_req_if.sink    req_ch,
   vca_rsp_if.source  rsp_ch,
   vca_csr_if.sink    csr_ch
);
   import vca_pkg::*;

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic                legacy_ff, legacy_in;
   logic [CNT_W-1:0]    live_n;
   logic                push, pop;
   item_type            push_item, head;
   queue_status_type    q_status;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      active_in = active_ff;
      legacy_in = legacy_ff;
      if (csr_ch.valid) begin
         if (csr_ch.index == REG_ACTIVE_CHANNELS) begin
            active_in = csr_ch.data[ACTIVE_W-1:0];
         end else if (csr_ch.index == REG_LEGACY_STOP) begin
            legacy_in = csr_ch.data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         legacy_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         legacy_ff <= legacy_in;
      end
   end

   // Clamp the active count into one through the built channel count.
   always_comb begin
      if (active_ff == '0) begin
         live_n = CNT_W'(1);
      end else if (32'(active_ff) > 32'(MAX_CHANNELS)) begin
         live_n = CNT_W'(MAX_CHANNELS);
      end else begin
         live_n = CNT_W'(active_ff);
      end
   end

   vca_front #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .req_ch    (req_ch),
      .live_n    (live_n),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   vca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   vca_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .live_n      (live_n),
      .legacy_stop (legacy_ff),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== src/vca_checker.sv =====
// Port-level checks for the voice channel allocator, attached to the top
// level by a bind statement. Depends on vca_pkg and voice_channel_allocator.
`default_nettype none

module vca_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [vca_pkg::KIND_W-1:0]  rsp_kind,
   input logic [vca_pkg::CHAN_W-1:0]  rsp_channel,
   input logic [vca_pkg::SOUND_W-1:0] rsp_sound_id_res,
   input logic                        rsp_last
);
   import vca_pkg::*;

   // A stalled result holds its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_channel)
         && $stable(rsp_sound_id_res) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Reset empties the result register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A request's results come without gaps once one has been taken.
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside the results of one request");

   // Refusals and no-ops close a request and name no channel.
   a_rsp_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REFUSED || rsp_kind == KIND_NOTHING)
         |-> rsp_last && (rsp_channel == '0))
      else $error("refusal or no-op is not a closing result");

endmodule

bind voice_channel_allocator vca_checker u_vca_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_channel      (rsp_ch.channel),
   .rsp_sound_id_res (rsp_ch.sound_id_res),
   .rsp_last         (rsp_ch.last)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the voice channel allocator: a request driver and
// a result checker with their own model of the channel table and its registers.
// Depends on vca_pkg, the channel interfaces in vca_if and the allocator itself.
`default_nettype none

module testbench;
   import vca_pkg::*;

   localparam int CHANNELS         = MAX_CHANNELS_DEF;
   localparam int NUM_SETTINGS     = 8;
   localparam int RANDOM_PER_PHASE = 58;
   localparam int SETTLE_CYCLES    = 12;
   localparam int STALL_LIMIT      = 3000;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [ORIGIN_W-1:0] origin_id;
      logic [SOUND_W-1:0]  sound_id;
      logic [PRIO_W-1:0]   priority_req;
      logic                pickup_flag;
      logic [CHAN_W-1:0]   ended_channel;
   } voice_req_type;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  channel;
      logic [SOUND_W-1:0] sound_id_res;
      logic               last;
   } voice_result_type;

   logic clock;
   logic reset;

   vca_req_if req_if ();
   vca_rsp_if rsp_if ();
   vca_csr_if csr_if ();

   voice_channel_allocator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Requests waiting to be sent and results waiting to arrive.
   voice_req_type    pending_reqs[$];
   voice_result_type expected_results[$];
   voice_result_type step_results[$];

   // Model of the channel table and its registers.
   logic                chan_busy  [CHANNELS];
   logic [ORIGIN_W-1:0] chan_origin[CHANNELS];
   logic                chan_pick  [CHANNELS];
   logic [PRIO_W-1:0]   chan_prio  [CHANNELS];
   logic [SOUND_W-1:0]  chan_sound [CHANNELS];
   logic [ACTIVE_W-1:0] cfg_active;
   logic                cfg_legacy;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int reqs_accepted;
   int results_seen;
   int stops_seen;
   int assigns_seen;
   int refusals_seen;
   int stall_cycles;

   // Settings walked through by the phases, extremes included.
   logic [CSR_DATA_W-1:0] setting_active[NUM_SETTINGS] =
      '{4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd6, 4'd2, 4'd8};
   logic [CSR_DATA_W-1:0] setting_legacy[NUM_SETTINGS] =
      '{4'h0, 4'h1, 4'h0, 4'hF, 4'hE, 4'h1, 4'h0, 4'h3};

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Append one result for the current request, up to the per-request limit.
   function automatic void add_result(input logic [KIND_W-1:0] kind, input int ch,
                                      input logic [SOUND_W-1:0] snd);
      voice_result_type res;
      if (step_results.size() < MAX_RESULTS) begin
         res.kind         = kind;
         res.channel      = CHAN_W'(ch);
         res.sound_id_res = snd;
         res.last         = 1'b0;
         step_results.push_back(res);
      end
   endfunction

   function automatic void release_channel(input int ch);
      if (chan_busy[ch]) begin
         chan_busy[ch] = 1'b0;
         add_result(KIND_STOPPED, ch, chan_sound[ch]);
      end
   endfunction

   // Work out the results of one accepted request and update the table.
   task automatic predict_request(input voice_req_type r);
      int n;
      int c;
      logic refused;
      n = (cfg_active < 1) ? 1 : ((cfg_active > CHANNELS) ? CHANNELS : int'(cfg_active));
      refused = 1'b0;
      step_results.delete();
      case (r.opcode)
         OP_START: begin
            // Stop an older sound from the same origin.
            for (c = 0; c < n; c++) begin
               if (chan_busy[c] && chan_origin[c] == r.origin_id &&
                   (cfg_legacy || chan_pick[c] == r.pickup_flag)) begin
                  release_channel(c);
                  break;
               end
            end
            // Find the first free channel, reusing a matching busy one on the way.
            for (c = 0; c < n && chan_busy[c]; c++) begin
               if (r.origin_id != 0 && chan_origin[c] == r.origin_id &&
                   chan_pick[c] == r.pickup_flag) begin
                  release_channel(c);
                  break;
               end
            end
            // All channels busy: steal by priority or refuse.
            if (c == n) begin
               for (c = 0; c < n; c++) begin
                  if (chan_prio[c] >= r.priority_req) break;
               end
               if (c == n) begin
                  refused = 1'b1;
                  add_result(KIND_REFUSED, 0, r.sound_id);
               end else begin
                  release_channel(c);
               end
            end
            if (!refused) begin
               chan_busy[c]   = 1'b1;
               chan_origin[c] = r.origin_id;
               chan_pick[c]   = r.pickup_flag;
               chan_prio[c]   = r.priority_req;
               chan_sound[c]  = r.sound_id;
               add_result(KIND_ASSIGNED, c, r.sound_id);
            end
         end
         OP_SILENCE: begin
            for (c = 0; c < n; c++) begin
               if (chan_busy[c] && chan_origin[c] == r.origin_id) begin
                  release_channel(c);
                  break;
               end
            end
         end
         OP_STOP_ALL: begin
            for (c = 0; c < n; c++) release_channel(c);
         end
         default: begin
            if (r.ended_channel < n) release_channel(r.ended_channel);
         end
      endcase
      if (step_results.size() == 0) add_result(KIND_NOTHING, 0, '0);
      step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
   endtask

   task automatic push_request(input logic [OPCODE_W-1:0] op, input logic [ORIGIN_W-1:0] org,
                               input logic [SOUND_W-1:0] snd, input logic [PRIO_W-1:0] pri,
                               input logic pick, input logic [CHAN_W-1:0] ended);
      voice_req_type r;
      r.opcode        = op;
      r.origin_id     = org;
      r.sound_id      = snd;
      r.priority_req  = pri;
      r.pickup_flag   = pick;
      r.ended_channel = ended;
      pending_reqs.push_back(r);
   endtask

   // Mostly starts from a small set of origins, so restarts, steals and
   // refusals happen often; the rest frees channels.
   function automatic voice_req_type random_request();
      voice_req_type r;
      int pick_op;
      pick_op = $urandom_range(99);
      if (pick_op < 60)      r.opcode = OP_START;
      else if (pick_op < 72) r.opcode = OP_SILENCE;
      else if (pick_op < 77) r.opcode = OP_STOP_ALL;
      else                   r.opcode = OP_ENDED;
      if ($urandom_range(99) < 75) begin
         case ($urandom_range(5))
            0: r.origin_id = 16'h0000;
            1: r.origin_id = 16'h0001;
            2: r.origin_id = 16'h0002;
            3: r.origin_id = 16'h00FF;
            4: r.origin_id = 16'h8000;
            default: r.origin_id = 16'hFFFF;
         endcase
      end else begin
         r.origin_id = ORIGIN_W'($urandom_range(16'hFFFF));
      end
      r.sound_id      = SOUND_W'($urandom_range(1023));
      r.priority_req  = PRIO_W'($urandom_range(255));
      r.pickup_flag   = 1'($urandom_range(1));
      r.ended_channel = CHAN_W'($urandom_range(7));
      return r;
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == REG_ACTIVE_CHANNELS) cfg_active = val;
      else if (idx == REG_LEGACY_STOP) cfg_legacy = val[0];
   endtask

   // Wait until every request is sent and every result has arrived.
   task automatic wait_until_drained();
      while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: holds a request until it is taken, then idles at random.
   always @(posedge clock) begin : drive_requests
      voice_req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_request(pending_reqs.pop_front());
            reqs_accepted++;
         end
         if (req_if.valid && !req_if.ready) begin
            // Request still waiting; keep it on the channel.
         end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs[0];
            req_if.valid         <= 1'b1;
            req_if.opcode        <= nxt.opcode;
            req_if.origin_id     <= nxt.origin_id;
            req_if.sound_id      <= nxt.sound_id;
            req_if.priority_req  <= nxt.priority_req;
            req_if.pickup_flag   <= nxt.pickup_flag;
            req_if.ended_channel <= nxt.ended_channel;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result checker: compares each result with the oldest expected one.
   always @(posedge clock) begin : check_results
      voice_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            case (rsp_if.kind)
               KIND_STOPPED:  stops_seen++;
               KIND_ASSIGNED: assigns_seen++;
               KIND_REFUSED:  refusals_seen++;
               default: ;
            endcase
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d channel %0d sound %0d",
                                         rsp_if.kind, rsp_if.channel, rsp_if.sound_id_res));
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.kind !== want.kind || rsp_if.channel !== want.channel ||
                   rsp_if.sound_id_res !== want.sound_id_res || rsp_if.last !== want.last) begin
                  report_mismatch($sformatf(
                     "got kind %0d ch %0d sound %0d last %0d, want %0d %0d %0d %0d",
                     rsp_if.kind, rsp_if.channel, rsp_if.sound_id_res, rsp_if.last,
                     want.kind, want.channel, want.sound_id_res, want.last));
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends the run when no channel moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", stall_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Main sequence: reset, then one phase per register setting.
   initial begin : run_phases
      int p;
      clock         = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.opcode = OP_START;
      req_if.origin_id     = '0;
      req_if.sound_id      = '0;
      req_if.priority_req  = '0;
      req_if.pickup_flag   = 1'b0;
      req_if.ended_channel = '0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.index  = REG_ACTIVE_CHANNELS;
      csr_if.data   = '0;
      cfg_active    = ACTIVE_RESET;
      cfg_legacy    = 1'b0;
      send_idle_pct = 36;
      recv_idle_pct = 78;
      mismatches    = 0;
      reqs_accepted = 0;
      results_seen  = 0;
      stops_seen    = 0;
      assigns_seen  = 0;
      refusals_seen = 0;
      stall_cycles  = 0;
      foreach (chan_busy[i]) chan_busy[i] = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < NUM_SETTINGS; p++) begin
         // Receiver-heavy idling first, then sender-heavy, then none.
         if (p < 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 78;
         end else if (p < 6) begin
            send_idle_pct = 78;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_register(REG_ACTIVE_CHANNELS, setting_active[p]);
         write_register(REG_LEGACY_STOP, setting_legacy[p]);

         if (p == 0) begin
            // Nothing to stop on an empty table.
            push_request(OP_STOP_ALL, 16'h0005, 10'd1, 8'd1, 1'b0, 3'd0);
            push_request(OP_SILENCE, 16'h0005, 10'd2, 8'd2, 1'b1, 3'd1);
            push_request(OP_ENDED, 16'h0000, 10'd3, 8'd3, 1'b0, 3'd7);
            // Extreme fields, then a zero-origin start and its restart.
            push_request(OP_START, 16'hFFFF, 10'd1023, 8'd255, 1'b1, 3'd7);
            push_request(OP_START, 16'h0000, 10'd0, 8'd0, 1'b0, 3'd0);
            push_request(OP_START, 16'h0000, 10'd5, 8'd10, 1'b0, 3'd0);
            // Same origin with the other pickup flag takes a new channel.
            push_request(OP_START, 16'hFFFF, 10'd7, 8'd20, 1'b0, 3'd0);
            // Fill the rest of the table.
            push_request(OP_START, 16'h0101, 10'd101, 8'd50, 1'b0, 3'd0);
            push_request(OP_START, 16'h0202, 10'd102, 8'd90, 1'b1, 3'd0);
            push_request(OP_START, 16'h0303, 10'd103, 8'd130, 1'b0, 3'd0);
            push_request(OP_START, 16'h0404, 10'd104, 8'd170, 1'b1, 3'd0);
            push_request(OP_START, 16'h0505, 10'd105, 8'd210, 1'b0, 3'd0);
            // Full table: steal by priority, then a refusal.
            push_request(OP_START, 16'h7777, 10'd300, 8'd0, 1'b1, 3'd0);
            push_request(OP_START, 16'h8888, 10'd301, 8'd255, 1'b0, 3'd0);
            // Voice ended on a busy channel, then on the same idle channel.
            push_request(OP_ENDED, 16'h0000, 10'd0, 8'd0, 1'b0, 3'd2);
            push_request(OP_ENDED, 16'h0000, 10'd0, 8'd0, 1'b0, 3'd2);
            push_request(OP_SILENCE, 16'h0101, 10'd0, 8'd0, 1'b0, 3'd0);
            push_request(OP_START, 16'hAAAA, 10'd512, 8'd128, 1'b1, 3'd5);
            push_request(OP_STOP_ALL, 16'h0000, 10'd0, 8'd0, 1'b0, 3'd0);
         end
         repeat (RANDOM_PER_PHASE) pending_reqs.push_back(random_request());
         wait_until_drained();
      end

      $display("covered %0d requests over %0d register settings", reqs_accepted, NUM_SETTINGS);
      $display("checked %0d results: %0d stops, %0d assignments, %0d refusals, %0d mismatches",
               results_seen, stops_seen, assigns_seen, refusals_seen, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
